FILE: rtl/bps_pkg.sv
// bps_pkg: shared types, codes and widths for the bilinear pixel sampler
// no dependencies
package bps_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_NEAREST = 2'd1,
        FUNC_BILIN   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_FALLBACK = 2'd2;

    localparam int COORD_W = 17;
    localparam int SIDE_W  = 9;
    localparam int PIX_W   = 32;

endpackage

FILE: rtl/bilinear_pixel_sampler.sv
// bilinear_pixel_sampler: top level, address stage, four parity banks, blend stages
// depends on bps_pkg, bps_bank, bps_blend
//
// usage: s_ requests carry func, coord_x/coord_y (unsigned fixed point) and
// pixel_in. a write request stores pixel_in at the integer coordinates and
// gives no result; nearest and bilinear requests give one m_ result each.
// the image is held row-major at y*width+x in two copies, one for the upper
// and one for the lower tap row, each split into even and odd addresses, so
// all four bilinear taps are read in the same cycle.
// pipeline: tap setup, bank read, tap routing, horizontal mix, vertical mix
// and output register. throughput is one request per cycle, limited only by
// the output side. a stall on m_ready freezes the whole pipeline; a
// request is taken while the output register is full as long as the
// pipeline can advance. reset clears valid bits and sets the size registers
// (256 x 256, fallback 0); image contents are undefined until written.
// configuration is plain write enable, index and data, taken at any clock
// edge.
module bilinear_pixel_sampler import bps_pkg::*; #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [PIX_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [COORD_W-1:0] s_coord_x,
    input  logic [COORD_W-1:0] s_coord_y,
    input  logic [PIX_W-1:0]   s_pixel_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic               m_used_fallback
);
    localparam int SW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int INT_W  = COORD_W - FRAC_BITS;
    localparam int TW     = INT_W + 1;
    localparam int AW     = 2 * SW;
    localparam int BW     = AW - 1;

    // configuration
    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [PIX_W-1:0]  fallback_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SIDE_W'(256);
            height_reg   <= SIDE_W'(256);
            fallback_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data[SIDE_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[SIDE_W-1:0];
                REG_FALLBACK: fallback_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [TW-1:0] eff_w, eff_h;
    assign eff_w = (int'(width_reg) > MAX_SIDE) ? TW'(MAX_SIDE) : TW'(width_reg);
    assign eff_h = (int'(height_reg) > MAX_SIDE) ? TW'(MAX_SIDE) : TW'(height_reg);

    // pipeline advance
    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    assign advance = !out_v_reg || m_ready;
    assign s_ready = advance;

    // stage 0: tap coordinates
    logic [FRAC_BITS-1:0] fx, fy;
    logic [TW-1:0] x0, y0, x1, y1, xn, yn;
    logic [COORD_W:0] rx, ry;
    assign fx = s_coord_x[FRAC_BITS-1:0];
    assign fy = s_coord_y[FRAC_BITS-1:0];
    assign x0 = TW'(s_coord_x[COORD_W-1:FRAC_BITS]);
    assign y0 = TW'(s_coord_y[COORD_W-1:FRAC_BITS]);
    assign x1 = x0 + TW'(fx != '0);
    assign y1 = y0 + TW'(fy != '0);
    assign rx = {1'b0, s_coord_x} + (COORD_W+1)'(1 << (FRAC_BITS-1));
    assign ry = {1'b0, s_coord_y} + (COORD_W+1)'(1 << (FRAC_BITS-1));
    assign xn = rx[COORD_W:FRAC_BITS];
    assign yn = ry[COORD_W:FRAC_BITS];

    logic accept;
    logic is_bil, is_near;
    assign accept  = s_valid && s_ready;
    assign is_bil  = s_func == FUNC_BILIN;
    assign is_near = s_func == FUNC_NEAREST;

    // column and row pair (a = floor or rounded tap, b = ceiling tap)
    logic [TW-1:0] xa, xb, ya, yb;
    assign xa = is_near ? xn : x0;
    assign ya = is_near ? yn : y0;
    assign xb = is_bil ? x1 : xa;
    assign yb = is_bil ? y1 : ya;

    logic out_a_x, out_b_x, out_a_y, out_b_y;
    assign out_a_x = xa >= eff_w;
    assign out_b_x = xb >= eff_w;
    assign out_a_y = ya >= eff_h;
    assign out_b_y = yb >= eff_h;

    // linear address of the upper and lower tap rows
    logic [2*TW-1:0] row_base;
    logic [AW-1:0]   addr_t, addr_b;
    logic [AW:0]     addr_t_inc, addr_b_inc;
    logic            dx;
    assign row_base   = (2*TW)'(ya) * (2*TW)'(eff_w);
    assign addr_t     = AW'(row_base) + AW'(xa);
    assign addr_b     = (yb != ya) ? addr_t + AW'(eff_w) : addr_t;
    assign addr_t_inc = {1'b0, addr_t} + (AW+1)'(1);
    assign addr_b_inc = {1'b0, addr_b} + (AW+1)'(1);
    assign dx         = xb != xa;

    // write decode
    logic wr_in;
    assign wr_in = accept && s_func == FUNC_WRITE && x0 < eff_w && y0 < eff_h;

    // bank {row copy, parity}: even bank reads (a+1)/2, odd bank reads a/2
    logic [PIX_W-1:0] bank_q [4];
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam bit ODD     = (b % 2) == 1;
        localparam bit LOW_ROW = b >= 2;
        logic [BW-1:0] raddr;
        assign raddr = LOW_ROW ? (ODD ? addr_b[AW-1:1] : addr_b_inc[AW-1:1])
                               : (ODD ? addr_t[AW-1:1] : addr_t_inc[AW-1:1]);
        bps_bank #(.ADDR_W(BW)) u_bank (
            .aclk    (aclk),
            .wr_en   (wr_in && addr_t[0] == ODD),
            .wr_addr (addr_t[AW-1:1]),
            .wr_data (s_pixel_in),
            .rd_en   (advance),
            .rd_addr (raddr),
            .rd_data (bank_q[b])
        );
    end

    // stage 1 side data
    logic [FRAC_BITS-1:0] fx1_reg, fy1_reg;
    logic pt1_reg, pb1_reg, dx1_reg, bil1_reg;
    logic [3:0] oob1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= accept && (is_bil || is_near);
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            fx1_reg  <= is_bil ? fx : '0;
            fy1_reg  <= is_bil ? fy : '0;
            pt1_reg  <= addr_t[0];
            pb1_reg  <= addr_b[0];
            dx1_reg  <= dx;
            bil1_reg <= is_bil;
            // tap order: 00=(xa,ya) 01=(xb,ya) 10=(xa,yb) 11=(xb,yb)
            oob1_reg <= {out_b_x | out_b_y, out_a_x | out_b_y,
                         out_b_x | out_a_y, out_a_x | out_a_y};
        end
    end

    // stage 2: tap routing and fallback substitution
    logic [PIX_W-1:0] tap_c [4];
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            logic [1:0] bi;
            bi[1] = 1'(t >> 1);
            bi[0] = (bi[1] ? pb1_reg : pt1_reg) ^ (1'(t) & dx1_reg);
            tap_c[t] = oob1_reg[t] ? fallback_reg : bank_q[bi];
        end
    end
    logic [PIX_W-1:0] tap2_reg [4];
    logic [FRAC_BITS-1:0] fx2_reg, fy2_reg;
    logic fb2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            tap2_reg <= tap_c;
            fx2_reg  <= fx1_reg;
            fy2_reg  <= fy1_reg;
            fb2_reg  <= bil1_reg ? |oob1_reg : oob1_reg[0];
        end
    end

    // stage 3: horizontal mix
    logic [PIX_W-1:0] top_mix, bot_mix;
    bps_blend #(.FRAC_BITS(FRAC_BITS)) u_top (
        .aclk(aclk), .en(advance), .pix_a(tap2_reg[0]), .pix_b(tap2_reg[1]),
        .frac(fx2_reg), .pix_out(top_mix)
    );
    bps_blend #(.FRAC_BITS(FRAC_BITS)) u_bot (
        .aclk(aclk), .en(advance), .pix_a(tap2_reg[2]), .pix_b(tap2_reg[3]),
        .frac(fx2_reg), .pix_out(bot_mix)
    );
    logic [FRAC_BITS-1:0] fy3_reg;
    logic fb3_reg, fb4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            fy3_reg <= fy2_reg;
            fb3_reg <= fb2_reg;
            fb4_reg <= fb3_reg;
        end
    end

    // stage 4: vertical mix
    logic [PIX_W-1:0] vert_mix;
    bps_blend #(.FRAC_BITS(FRAC_BITS)) u_vert (
        .aclk(aclk), .en(advance), .pix_a(top_mix), .pix_b(bot_mix),
        .frac(fy3_reg), .pix_out(vert_mix)
    );

    // output register
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_fb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pix_reg <= vert_mix;
            out_fb_reg  <= fb4_reg;
        end
    end

    assign m_valid         = out_v_reg;
    assign m_pixel_out     = out_pix_reg;
    assign m_used_fallback = out_fb_reg;

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))
        else $error("result changed while stalled");
    // requests are taken exactly when the pipeline advances
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready out of step with output stage");
    // a valid sample in the horizontal mix stage moves on to the vertical mix stage on an advance
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && v3_reg |=> v4_reg)
        else $error("valid bit lost in pipeline");
endmodule

FILE: rtl/bps_blend.sv
// bps_blend: registered per-channel linear mix of two rgba pixels
// depends on bps_pkg
module bps_blend import bps_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [PIX_W-1:0]     pix_a,
    input  logic [PIX_W-1:0]     pix_b,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [PIX_W-1:0]     pix_out
);
    localparam int PROD_W = 8 + FRAC_BITS + 1;

    logic [PIX_W-1:0] mix_next;
    logic [PIX_W-1:0] mix_reg;

    always_comb begin
        logic [FRAC_BITS:0] wa;
        logic [PROD_W-1:0]  sum;
        wa = (FRAC_BITS+1)'(1) << FRAC_BITS;
        wa = wa - {1'b0, frac};
        mix_next = '0;
        for (int c = 0; c < 4; c++) begin
            sum = PROD_W'(pix_a[c*8 +: 8]) * PROD_W'(wa)
                + PROD_W'(pix_b[c*8 +: 8]) * PROD_W'(frac);
            mix_next[c*8 +: 8] = sum[FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mix_reg <= mix_next;
        end
    end

    assign pix_out = mix_reg;
endmodule

FILE: rtl/bps_bank.sv
// bps_bank: one parity bank of the image store, one write and one read port
// depends on bps_pkg
module bps_bank import bps_pkg::*; #(
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);
    logic [PIX_W-1:0] mem [2**ADDR_W];
    logic [PIX_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;
endmodule
